// ===== sv/fes_pkg.sv =====
package fes_pkg;

	// Field widths fixed by the channel definitions
	localparam int COORD_W = 6;
	localparam int PIX_W   = 8;
	localparam int SPK_W   = 5;
	localparam int RNG_W   = 32;
	localparam int CNT_W   = 5;

	// Default frame side and queue depth
	localparam int SIDE_DEF    = 64;
	localparam int QUEUE_DEPTH = 4;

	// Pixel levels
	localparam logic [PIX_W-1:0] IDLE_PIX    = 8'd96;
	localparam logic [PIX_W-1:0] DECAY_ABOVE = 8'd158;
	localparam logic [PIX_W-1:0] LIGHT_ABOVE = 8'd159;
	localparam logic [PIX_W-1:0] SPARK_PIX   = 8'd175;

	// Spark base in frame coordinates (bordered 16 less the border ring)
	localparam logic [COORD_W-1:0] SPARK_OFS = 6'd15;

	// Random generator
	localparam logic [RNG_W-1:0] RNG_SEED     = 32'h41C6167E;
	localparam logic [CNT_W-1:0] COUNT_RELOAD = 5'd31;
	localparam int               FOLD_SHIFT   = 4;

	// Operation kinds, same coding as the mode field
	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
		logic [SPK_W-1:0]   spark_row;
		logic [SPK_W-1:0]   spark_col;
	} op_t;

	typedef struct packed {
		logic [RNG_W-1:0] shift;
		logic [CNT_W-1:0] count;
	} rng_t;

	// One draw: rotate right and count down, or fold and reload
	function automatic rng_t rng_draw(rng_t s);
		rng_t n;
		n = s;
		if (s.count > 5'd1) begin
			n.count = s.count - 5'd1;
			n.shift = {s.shift[0], s.shift[RNG_W-1:1]};
		end else begin
			n.count = COUNT_RELOAD;
			n.shift = s.shift ^ (s.shift >> FOLD_SHIFT);
		end
		return n;
	endfunction

endpackage

// ===== sv/fes_if.sv =====
// Request channel: one beat per step
interface fes_req_if;
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [fes_pkg::SPK_W-1:0] spark_row;
	logic [fes_pkg::SPK_W-1:0] spark_col;

	modport source(output valid, mode, spark_row, spark_col, input ready);
	modport sink(input valid, mode, spark_row, spark_col, output ready);
endinterface

// Response channel: one beat per emitted pixel
interface fes_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [fes_pkg::PIX_W-1:0]   pixel;
	logic [fes_pkg::COORD_W-1:0] row;
	logic [fes_pkg::COORD_W-1:0] column;
	logic                        last_of_frame;

	modport source(output valid, pixel, row, column, last_of_frame, input ready);
	modport sink(input valid, pixel, row, column, last_of_frame, output ready);
endinterface

// ===== sv/fes_front.sv =====
module fes_front #(
	parameter int SIDE = fes_pkg::SIDE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	fes_req_if.sink       req,
	input  logic          q_full,
	output logic          push,
	output fes_pkg::op_t  push_op
);

	localparam logic [fes_pkg::COORD_W-1:0] LAST_RC = fes_pkg::COORD_W'(SIDE - 1);

	logic                        sparks_en_q;
	logic [fes_pkg::COORD_W-1:0] row_q;
	logic [fes_pkg::COORD_W-1:0] col_q;
	logic                        accept;
	logic                        is_clear;
	logic                        last;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;
	assign is_clear  = (req.mode == fes_pkg::OP_CLEAR);
	assign last      = (row_q == LAST_RC) && (col_q == LAST_RC);

	// Clears always go down; pixel steps only while sparks are enabled
	assign push = accept && (is_clear || sparks_en_q);

	always_comb begin
		push_op           = '0;
		push_op.kind      = req.mode;
		push_op.row       = row_q;
		push_op.col       = col_q;
		push_op.last      = last;
		push_op.spark_row = req.spark_row;
		push_op.spark_col = req.spark_col;
	end

	// Config register and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sparks_en_q <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
		end else begin
			if (cfg_we) begin
				sparks_en_q <= cfg_wdata;
			end
			if (accept) begin
				if (is_clear) begin
					row_q <= '0;
					col_q <= '0;
				end else if (sparks_en_q) begin
					if (col_q == LAST_RC) begin
						col_q <= '0;
						row_q <= last ? '0 : row_q + fes_pkg::COORD_W'(1);
					end else begin
						col_q <= col_q + fes_pkg::COORD_W'(1);
					end
				end
			end
		end
	end

endmodule

// ===== sv/fes_queue.sv =====
module fes_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fes_pkg::op_t  push_op,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output fes_pkg::op_t  head
);

	localparam int PTR_W = $clog2(fes_pkg::QUEUE_DEPTH);

	fes_pkg::op_t     entries_q [fes_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W+1)'(fes_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== sv/fes_back.sv =====
module fes_back #(
	parameter int SIDE = fes_pkg::SIDE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  fes_pkg::op_t  q_head,
	output logic          q_pop,
	fes_rsp_if.source     rsp
);

	localparam int CW     = fes_pkg::COORD_W;
	localparam int PW     = fes_pkg::PIX_W;
	localparam int BROW_W = CW - 1;
	localparam int ADDR_W = 1 + BROW_W + CW;
	localparam int DEPTH  = 2 ** ADDR_W;
	localparam logic [CW:0]   SIDE_X  = (CW+1)'(SIDE);
	localparam logic [CW-1:0] LAST_RC = CW'(SIDE - 1);

	function automatic logic [PW-1:0] max2(logic [PW-1:0] a, logic [PW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// Frame buffers split by row parity; the top address bit picks the buffer
	logic [PW-1:0] mem_e [DEPTH];
	logic [PW-1:0] mem_o [DEPTH];
	logic [PW-1:0] rd_e0_q, rd_e1_q, rd_o0_q, rd_o1_q;

	// Frame state
	logic buf_q;
	logic blank_q;
	logic spark_pend_q;
	logic [CW-1:0] spark_row_q, spark_col_q;

	// Read stage
	logic          s1_valid_q;
	logic          s1_primed_q;
	fes_pkg::op_t  s1_op_q;
	logic          is_clear, need_prime, hazard, s1_go, s1_clear, s1_done;
	logic [CW:0]   col_rd;
	logic [CW-1:0] row_up, row_dn;
	logic          idle_a, idle_b, idle_d;
	logic [ADDR_W-1:0] addr_a, addr_b, addr_d, addr_e0, addr_o0;

	// Compute stage
	logic                s2_valid_s2;
	logic                prime_s2;
	logic [CW-1:0]       row_s2, col_s2;
	logic                last_s2;
	logic [fes_pkg::SPK_W-1:0] srow_s2, scol_s2;
	logic                idle_a_s2, idle_b_s2, idle_d_s2;
	logic                s2_fire, pix_fire, s2_free, out_free;

	// Window: w1/w2 are up-left/up, m1/m2 are left/center of the next pixel
	logic [PW-1:0] w1_q, w2_q, m1_q, m2_q;
	logic [PW-1:0] rd_a, rd_b, rd_d, nb_max, center, v;
	fes_pkg::rng_t rng_q, rng1, rng2, rng_nx;

	// Write port, shared address for both parity banks
	logic              we_e, we_o, wr_odd;
	logic [ADDR_W-1:0] wr_addr;
	logic [PW-1:0]     wr_data;

	// Output register
	logic          rsp_valid_q;
	logic [PW-1:0] rsp_pixel_q;
	logic [CW-1:0] rsp_row_q, rsp_col_q;
	logic          rsp_last_q;

	// ---- read stage ----
	assign is_clear   = (s1_op_q.kind == fes_pkg::OP_CLEAR);
	assign need_prime = (s1_op_q.col == '0) && !s1_primed_q;
	assign col_rd     = need_prime ? {1'b0, s1_op_q.col} : {1'b0, s1_op_q.col} + (CW+1)'(1);
	assign row_up     = s1_op_q.row - CW'(1);
	assign row_dn     = s1_op_q.row + CW'(1);

	// Border cells and a cleared store read as background
	assign idle_a = blank_q || (s1_op_q.row == '0) || (col_rd >= SIDE_X);
	assign idle_b = blank_q || (col_rd >= SIDE_X);
	assign idle_d = blank_q || (s1_op_q.row == LAST_RC);

	assign addr_a = {buf_q, row_up[CW-1:1], col_rd[CW-1:0]};
	assign addr_b = {buf_q, s1_op_q.row[CW-1:1], col_rd[CW-1:0]};
	assign addr_d = {buf_q, row_dn[CW-1:1], s1_op_q.col};

	// Rows above and below share a parity bank, the own row uses the other
	assign addr_e0 = s1_op_q.row[0] ? addr_a : addr_b;
	assign addr_o0 = s1_op_q.row[0] ? addr_b : addr_a;

	// Hold reads while the frame swap is in progress
	assign hazard   = (s2_valid_s2 && !prime_s2 && last_s2) || spark_pend_q;
	assign s1_go    = s1_valid_q && !hazard && !is_clear && s2_free;
	assign s1_clear = s1_valid_q && !hazard && is_clear;
	assign s1_done  = s1_clear || (s1_go && !need_prime);
	assign q_pop    = !q_empty && (!s1_valid_q || s1_done);

	// ---- compute stage ----
	assign out_free = !rsp_valid_q || rsp.ready;
	assign s2_fire  = s2_valid_s2 && (prime_s2 || out_free);
	assign pix_fire = s2_fire && !prime_s2;
	assign s2_free  = !s2_valid_s2 || s2_fire;

	assign rd_a = idle_a_s2 ? fes_pkg::IDLE_PIX : (row_s2[0] ? rd_e0_q : rd_o0_q);
	assign rd_b = idle_b_s2 ? fes_pkg::IDLE_PIX : (row_s2[0] ? rd_o0_q : rd_e0_q);
	assign rd_d = idle_d_s2 ? fes_pkg::IDLE_PIX : (row_s2[0] ? rd_e1_q : rd_o1_q);
	assign center = m2_q;

	// Six-neighbor maximum as a small tree
	assign nb_max = max2(max2(max2(w1_q, w2_q), max2(rd_a, m1_q)), max2(rd_b, rd_d));

	assign rng1 = fes_pkg::rng_draw(rng_q);
	assign rng2 = fes_pkg::rng_draw(rng1);

	// Pixel update and random draws
	always_comb begin
		v      = fes_pkg::IDLE_PIX;
		rng_nx = rng_q;
		if (center != fes_pkg::IDLE_PIX) begin
			v = (center > fes_pkg::DECAY_ABOVE) ? center - PW'(1) : fes_pkg::IDLE_PIX;
		end else if (rng_q.shift[0]) begin
			rng_nx = rng1;
		end else if (nb_max <= fes_pkg::LIGHT_ABOVE) begin
			rng_nx = rng1;
		end else begin
			rng_nx = rng2;
			v      = rng1.shift[0] ? nb_max : nb_max - PW'(1);
		end
	end

	// Pixel goes to the other buffer; the spark follows the frame's last pixel
	assign wr_odd  = spark_pend_q ? spark_row_q[0] : row_s2[0];
	assign wr_addr = spark_pend_q ? {~buf_q, spark_row_q[CW-1:1], spark_col_q}
	                              : {~buf_q, row_s2[CW-1:1], col_s2};
	assign wr_data = spark_pend_q ? fes_pkg::SPARK_PIX : v;
	assign we_e    = (pix_fire || spark_pend_q) && !wr_odd;
	assign we_o    = (pix_fire || spark_pend_q) && wr_odd;

	// Even-row bank
	always_ff @(posedge clk) begin
		if (we_e) begin
			mem_e[wr_addr] <= wr_data;
		end
		if (s1_go) begin
			rd_e0_q <= mem_e[addr_e0];
			rd_e1_q <= mem_e[addr_d];
		end
	end

	// Odd-row bank
	always_ff @(posedge clk) begin
		if (we_o) begin
			mem_o[wr_addr] <= wr_data;
		end
		if (s1_go) begin
			rd_o0_q <= mem_o[addr_o0];
			rd_o1_q <= mem_o[addr_d];
		end
	end

	// Stage payloads and window
	always_ff @(posedge clk) begin
		if (q_pop) begin
			s1_op_q <= q_head;
		end
		if (s1_go) begin
			prime_s2  <= need_prime;
			row_s2    <= s1_op_q.row;
			col_s2    <= s1_op_q.col;
			last_s2   <= s1_op_q.last;
			srow_s2   <= s1_op_q.spark_row;
			scol_s2   <= s1_op_q.spark_col;
			idle_a_s2 <= idle_a;
			idle_b_s2 <= idle_b;
			idle_d_s2 <= idle_d;
		end
		if (s2_fire) begin
			if (prime_s2) begin
				w1_q <= fes_pkg::IDLE_PIX;
				m1_q <= fes_pkg::IDLE_PIX;
			end else begin
				w1_q <= w2_q;
				m1_q <= m2_q;
			end
			w2_q <= rd_a;
			m2_q <= rd_b;
		end
		if (pix_fire && last_s2) begin
			spark_row_q <= fes_pkg::SPARK_OFS + CW'(srow_s2);
			spark_col_q <= fes_pkg::SPARK_OFS + CW'(scol_s2);
		end
		if (pix_fire) begin
			rsp_pixel_q <= (v == fes_pkg::IDLE_PIX) ? '0 : v;
			rsp_row_q   <= row_s2;
			rsp_col_q   <= col_s2;
			rsp_last_q  <= last_s2;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			s1_primed_q  <= 1'b0;
			s2_valid_s2  <= 1'b0;
			buf_q        <= 1'b0;
			blank_q      <= 1'b1;
			spark_pend_q <= 1'b0;
			rng_q        <= '{shift: fes_pkg::RNG_SEED, count: fes_pkg::COUNT_RELOAD};
			rsp_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_go && need_prime) begin
				s1_primed_q <= 1'b1;
			end else if (s1_done) begin
				s1_primed_q <= 1'b0;
			end

			if (s1_go) begin
				s2_valid_s2 <= 1'b1;
			end else if (s2_fire) begin
				s2_valid_s2 <= 1'b0;
			end

			// Frame swap in the same cycle as the spark write; a clear blanks the live frame
			spark_pend_q <= pix_fire && last_s2;
			if (spark_pend_q) begin
				buf_q   <= ~buf_q;
				blank_q <= 1'b0;
			end else if (s1_clear) begin
				blank_q <= 1'b1;
			end

			if (pix_fire) begin
				rng_q <= rng_nx;
			end

			if (pix_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.pixel         = rsp_pixel_q;
	assign rsp.row           = rsp_row_q;
	assign rsp.column        = rsp_col_q;
	assign rsp.last_of_frame = rsp_last_q;

endmodule

// ===== sv/fire_effect_stencil_top.sv =====
// Path: req, queue, read stage, compute stage, output register, rsp; the first
// pixel of a row primes the neighbor window first. Throughput: one pixel per
// cycle along a row while rsp is ready; a row start adds the priming step and a
// frame end holds reads (last pixel write, then spark write and buffer swap).
// Reset: sparks disabled, raster at the origin, live frame reads as background,
// random generator at its seed; no clearing pass, items are taken at once.
module fire_effect_stencil_top #(
	parameter int SIDE = fes_pkg::SIDE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	fes_req_if.sink   req,
	fes_rsp_if.source rsp
);

	logic         push, pop, full, empty;
	fes_pkg::op_t push_op, head;

	// Front: accepts beats, tracks the raster, classifies steps
	fes_front #(
		.SIDE(SIDE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.q_full   (full),
		.push     (push),
		.push_op  (push_op)
	);

	// Decoupling queue
	fes_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	// Back: frame buffers, stencil compute, output register
	fes_back #(
		.SIDE(SIDE)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(empty),
		.q_head (head),
		.q_pop  (pop),
		.rsp    (rsp)
	);

endmodule
